// File: src/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg: shared types and constants of the breakpoint interpolator
// Datapath widths, result codes, sequencer states and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbi_pkg;

  localparam int DATA_W = 32;   // Q16.16 word
  localparam int TOL_W  = 31;   // tolerance and clean span
  localparam int XW     = 34;   // x of a bracket point, room for +/-1.0
  localparam int NUM_W  = 64;   // divider numerator
  localparam int DEN_W  = 36;   // divider denominator
  localparam int STAT_W = 3;

  localparam logic signed [XW-1:0]    Q_ONE  = 34'sd65536;
  localparam logic        [TOL_W-1:0] W_ONE  = 31'd1073741824;
  localparam logic signed [NUM_W-1:0] W_BIAS = 64'sd1073741823;

  // result codes
  localparam logic [STAT_W-1:0] ST_EVAL    = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_INSERT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_REPLACE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_START,
    S_INS_SCAN, S_INS_PLACE, S_INS_SH_WR, S_INS_WRITE, S_PG_CHK, S_INS_FIN,
    S_EV_LO, S_EV_HI, S_EV_SCAN, S_EV_P2, S_EV_P3, S_EV_P0,
    S_EV_DIV, S_EV_DIVW, S_EV_MLO, S_EV_MHI, S_EV_MSUM, S_EV_MFIN,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {DIV_W, DIV_SA, DIV_SB, DIV_SC, DIV_A1, DIV_A2} div_op_t;
  typedef enum logic [2:0] {MUL_NONE, MUL_LO, MUL_HI, MUL_SUM, MUL_FIN} mul_step_t;
  typedef enum logic [1:0] {BL_VALUE, BL_SLOPE, BL_CURV} blend_t;
  typedef enum logic [1:0] {PT_0, PT_1, PT_2, PT_3} point_t;

  typedef struct packed {
    logic              ld_in;
    logic              rd_en;
    logic              wr_en;
    logic              wr_new;
    logic              ld_pt;
    point_t            pt;
    logic              pt_syn;
    logic              div_start;
    logic              div_store;
    div_op_t           div_op;
    mul_step_t         mul_step;
    blend_t            blend;
    logic              out_load;
    logic              out_zero;
    logic [STAT_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic req_eval;
    logic match;
    logic key_gt;
    logic key_lt;
    logic keep;
    logic span_pos;
    logic div_done;
  } dp_stat_t;

  // saturate to a signed 32-bit word
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sbi_ram.sv
// ----------------------------------------------------------------------------
// sbi_ram: simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/sbi_div.sv
// ----------------------------------------------------------------------------
// sbi_div: signed radix-2 divider
// Restoring division on magnitudes, one quotient bit a cycle, quotient
// truncated toward zero; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [sbi_pkg::NUM_W-1:0]  num,
  input  wire logic signed [sbi_pkg::DEN_W-1:0]  den,
  output logic                                   done,
  output logic signed      [sbi_pkg::NUM_W-1:0]  quo
);
  import sbi_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             fix;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] nmag;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dmag;
  logic             neg;
  logic             dz;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem[DEN_W-1:0], nmag[NUM_W-1]};
    diff    = shifted - {1'b0, dmag};
    fits    = shifted >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem  <= '0;
        neg  <= num[NUM_W-1] ^ den[DEN_W-1];
        dz   <= (den == '0);
      end else if (busy) begin
        rem  <= fits ? diff : shifted;
        nmag <= {nmag[NUM_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        // sign fix-up
        fix  <= 1'b0;
        done <= 1'b1;
        quo  <= dz ? '0 : (neg ? -$signed(nmag) : $signed(nmag));
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sbi_datapath.sv
// ----------------------------------------------------------------------------
// sbi_datapath: breakpoint store and arithmetic
// Holds the point RAMs, the tolerance register, the bracket points, the
// shared divider, the blend multiplier and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire sbi_pkg::dp_cmd_t                      cmd,
  output sbi_pkg::dp_stat_t                          stat,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]      total,
  input  wire logic                                  req_type,
  input  wire logic signed [sbi_pkg::DATA_W-1:0]     key_x,
  input  wire logic signed [sbi_pkg::DATA_W-1:0]     value_y,
  input  wire logic [sbi_pkg::TOL_W-1:0]             clean_span,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [2:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready,
  output logic signed [sbi_pkg::DATA_W-1:0]          value_out,
  output logic signed [sbi_pkg::DATA_W-1:0]          slope_out,
  output logic signed [sbi_pkg::DATA_W-1:0]          curvature_out,
  output logic [sbi_pkg::STAT_W-1:0]                 status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]           point_total
);
  import sbi_pkg::*;

  // latched word and configuration
  logic                     req_eval;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] val;
  logic [TOL_W-1:0]         span;
  logic [TOL_W-1:0]         tol;

  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;
  logic signed [DATA_W-1:0] wd_x;
  logic signed [DATA_W-1:0] wd_y;

  // bracket points and intermediate terms
  logic signed [XW-1:0]     x0, x1, x2, x3;
  logic signed [DATA_W-1:0] y0, y1, y2, y3;
  logic [TOL_W-1:0]         w;
  logic signed [DATA_W-1:0] sa, sb, sc, a1, a2;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  acc;
  logic signed [DATA_W-1:0] res_v, res_s, res_c;

  // APB register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tol <= pwdata[TOL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, tol};

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      req_eval <= req_type;
      key      <= key_x;
      val      <= value_y;
      span     <= clean_span;
    end
  end

  // point store
  assign wd_x = cmd.wr_new ? key : rd_x;
  assign wd_y = cmd.wr_new ? val : rd_y;

  sbi_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wd_x),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_x)
  );

  sbi_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wd_y),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_y)
  );

  // compares of the key against the word just read
  logic signed [DATA_W:0] dk;
  logic signed [DATA_W:0] dp;
  logic        [DATA_W:0] adk;

  always_comb begin
    dk  = {key[DATA_W-1], key} - {rd_x[DATA_W-1], rd_x};
    dp  = {rd_x[DATA_W-1], rd_x} - {key[DATA_W-1], key};
    adk = dk[DATA_W] ? dp : dk;
  end

  logic div_done;

  assign stat.req_eval = req_eval;
  assign stat.match    = adk < {2'b00, tol};
  assign stat.key_gt   = dk > 0;
  assign stat.key_lt   = dk < 0;
  assign stat.keep     = dp >= $signed({2'b00, span});
  assign stat.span_pos = span != '0;
  assign stat.div_done = div_done;

  // bracket point load, missing neighbours 1.0 away
  logic signed [XW-1:0] rd_xe;
  assign rd_xe = {{(XW-DATA_W){rd_x[DATA_W-1]}}, rd_x};

  always_ff @(posedge clk) begin
    if (cmd.ld_pt) begin
      case (cmd.pt)
        PT_0: begin
          x0 <= cmd.pt_syn ? x1 - Q_ONE : rd_xe;
          y0 <= cmd.pt_syn ? y1 : rd_y;
        end
        PT_1: begin
          x1 <= rd_xe;
          y1 <= rd_y;
        end
        PT_2: begin
          x2 <= cmd.pt_syn ? x1 + Q_ONE : rd_xe;
          y2 <= cmd.pt_syn ? y1 : rd_y;
        end
        PT_3: begin
          x3 <= cmd.pt_syn ? x2 + Q_ONE : rd_xe;
          y3 <= cmd.pt_syn ? y2 : rd_y;
        end
        default: begin
          x1 <= rd_xe;
          y1 <= rd_y;
        end
      endcase
    end
  end

  // divider operands
  logic signed [XW-1:0]     kx;
  logic signed [XW-1:0]     dkx;
  logic signed [XW:0]       dx21, dx10, dx32, dx20, dx31;
  logic signed [DATA_W:0]   dy10, dy21, dy32, dsba, dscb;
  logic signed [NUM_W-1:0]  div_num;
  logic signed [DEN_W-1:0]  div_den;
  logic signed [NUM_W-1:0]  quo;

  always_comb begin
    kx   = {{(XW-DATA_W){key[DATA_W-1]}}, key};
    dkx  = kx - x1;
    dx21 = {x2[XW-1], x2} - {x1[XW-1], x1};
    dx10 = {x1[XW-1], x1} - {x0[XW-1], x0};
    dx32 = {x3[XW-1], x3} - {x2[XW-1], x2};
    dx20 = {x2[XW-1], x2} - {x0[XW-1], x0};
    dx31 = {x3[XW-1], x3} - {x1[XW-1], x1};
    dy10 = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};
    dy21 = {y2[DATA_W-1], y2} - {y1[DATA_W-1], y1};
    dy32 = {y3[DATA_W-1], y3} - {y2[DATA_W-1], y2};
    dsba = {sb[DATA_W-1], sb} - {sa[DATA_W-1], sa};
    dscb = {sc[DATA_W-1], sc} - {sb[DATA_W-1], sb};
    case (cmd.div_op)
      DIV_W: begin
        div_num = {{(NUM_W-XW){dkx[XW-1]}}, dkx} <<< 30;
        div_den = {dx21[XW], dx21};
      end
      DIV_SA: begin
        div_num = {{(NUM_W-DATA_W-1){dy10[DATA_W]}}, dy10} <<< 16;
        div_den = {dx10[XW], dx10};
      end
      DIV_SB: begin
        div_num = {{(NUM_W-DATA_W-1){dy21[DATA_W]}}, dy21} <<< 16;
        div_den = {dx21[XW], dx21};
      end
      DIV_SC: begin
        div_num = {{(NUM_W-DATA_W-1){dy32[DATA_W]}}, dy32} <<< 16;
        div_den = {dx32[XW], dx32};
      end
      DIV_A1: begin
        div_num = {{(NUM_W-DATA_W-1){dsba[DATA_W]}}, dsba} <<< 17;
        div_den = {dx20[XW], dx20};
      end
      DIV_A2: begin
        div_num = {{(NUM_W-DATA_W-1){dscb[DATA_W]}}, dscb} <<< 17;
        div_den = {dx31[XW], dx31};
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  sbi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // quotient store: weight clamped, slopes saturated
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_op)
        DIV_W: begin
          if (quo < 0) begin
            w <= '0;
          end else if (quo > $signed({{(NUM_W-TOL_W){1'b0}}, W_ONE})) begin
            w <= W_ONE;
          end else begin
            w <= quo[TOL_W-1:0];
          end
        end
        DIV_SA:  sa <= sat32(quo);
        DIV_SB:  sb <= sat32(quo);
        DIV_SC:  sc <= sat32(quo);
        DIV_A1:  a1 <= sat32(quo);
        DIV_A2:  a2 <= sat32(quo);
        default: sa <= sat32(quo);
      endcase
    end
  end

  // averaged slopes, halved toward zero
  logic signed [DATA_W:0]   s1, s2, s1r, s2r;
  logic signed [DATA_W-1:0] v1, v2;

  always_comb begin
    s1  = {sa[DATA_W-1], sa} + {sb[DATA_W-1], sb};
    s2  = {sb[DATA_W-1], sb} + {sc[DATA_W-1], sc};
    s1r = s1 + {{DATA_W{1'b0}}, s1[DATA_W]};
    s2r = s2 + {{DATA_W{1'b0}}, s2[DATA_W]};
    v1  = s1r[DATA_W:1];
    v2  = s2r[DATA_W:1];
  end

  // blend operand select
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [DATA_W-1:0] wt, wc;
  logic signed [NUM_W-1:0]  fin_t;
  logic signed [NUM_W-1:0]  fin_q;

  always_comb begin
    case (cmd.blend)
      BL_VALUE: begin
        mul_a = y1;
        mul_b = y2;
      end
      BL_SLOPE: begin
        mul_a = v1;
        mul_b = v2;
      end
      BL_CURV: begin
        mul_a = a1;
        mul_b = a2;
      end
      default: begin
        mul_a = y1;
        mul_b = y2;
      end
    endcase
    wt    = $signed({1'b0, w});
    wc    = $signed({1'b0, W_ONE - w});
    fin_t = acc + (acc[NUM_W-1] ? W_BIAS : '0);
    fin_q = fin_t >>> 30;
  end

  // blend: a*(1-w) then b*w, summed, scaled toward zero
  always_ff @(posedge clk) begin
    case (cmd.mul_step)
      MUL_LO: prod <= mul_a * wc;
      MUL_HI: begin
        acc  <= prod;
        prod <= mul_b * wt;
      end
      MUL_SUM: acc <= acc + prod;
      MUL_FIN: begin
        case (cmd.blend)
          BL_VALUE: res_v <= sat32(fin_q);
          BL_SLOPE: res_s <= sat32(fin_q);
          BL_CURV:  res_c <= sat32(fin_q);
          default:  res_v <= sat32(fin_q);
        endcase
      end
      default: acc <= acc;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value_out     <= cmd.out_zero ? '0 : res_v;
      slope_out     <= cmd.out_zero ? '0 : res_s;
      curvature_out <= cmd.out_zero ? '0 : res_c;
      status        <= cmd.out_status;
      point_total   <= total;
    end
  end

endmodule

`default_nettype wire

// File: src/sbi_ctrl.sv
// ----------------------------------------------------------------------------
// sbi_ctrl: sequencer of the breakpoint interpolator
// Runs the table scan, shift, purge and the evaluation sequence, keeps the
// point count and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sbi_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sbi_pkg::dp_cmd_t                       cmd,
  input  wire sbi_pkg::dp_stat_t                 stat,
  output logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr,
  output logic [$clog2(TABLE_DEPTH)-1:0]         wr_addr,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]       total
);
  import sbi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     k, k_next;
  logic [CW-1:0]     pos, pos_next;
  logic [CW-1:0]     dst, dst_next;
  logic [CW-1:0]     n, n_next;
  logic              repl, repl_next;
  logic [STAT_W-1:0] code, code_next;
  div_op_t           div_op, div_op_next;
  blend_t            blend, blend_next;
  logic              out_free;

  // index arithmetic, one bit wider so that k+2 never wraps
  logic [CW:0] kp1, kp2, posp1, cnt_e, n_e, nval_e;
  logic [CW-1:0] km1, km2, nval;

  // address of the entry just below a count
  function automatic logic [AW-1:0] km1_of(input logic [CW-1:0] c);
    logic [CW-1:0] t;
    t = c - CW'(1);
    return t[AW-1:0];
  endfunction

  always_comb begin
    km1    = k - CW'(1);
    km2    = k - CW'(2);
    kp1    = {1'b0, k} + (CW+1)'(1);
    kp2    = {1'b0, k} + (CW+1)'(2);
    posp1  = {1'b0, pos} + (CW+1)'(1);
    cnt_e  = {1'b0, count};
    n_e    = {1'b0, n};
    nval   = repl ? count : count + CW'(1);
    nval_e = {1'b0, nval};
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign total    = count;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    k      <= k_next;
    pos    <= pos_next;
    dst    <= dst_next;
    n      <= n_next;
    repl   <= repl_next;
    code   <= code_next;
    div_op <= div_op_next;
    blend  <= blend_next;
  end

  // next state
  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    pos_next    = pos;
    dst_next    = dst;
    n_next      = n;
    repl_next   = repl;
    code_next   = code;
    div_op_next = div_op;
    blend_next  = blend;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.req_eval) begin
          if (count == '0) begin
            code_next  = ST_RANGE;
            state_next = S_OUT;
          end else begin
            state_next = S_EV_LO;
          end
        end else begin
          repl_next = 1'b0;
          if (count == '0) begin
            pos_next   = '0;
            state_next = S_INS_PLACE;
          end else begin
            k_next     = count;
            state_next = S_INS_SCAN;
          end
        end
      end
      // scan down from the last point
      S_INS_SCAN: begin
        if (stat.match) begin
          pos_next   = km1;
          repl_next  = 1'b1;
          state_next = S_INS_WRITE;
        end else if (stat.key_gt) begin
          pos_next   = k;
          state_next = S_INS_PLACE;
        end else if (k == CW'(1)) begin
          pos_next   = '0;
          state_next = S_INS_PLACE;
        end else begin
          k_next = km1;
        end
      end
      S_INS_PLACE: begin
        if (count == FULL) begin
          code_next  = ST_FULL;
          state_next = S_OUT;
        end else begin
          k_next     = count;
          state_next = (count == pos) ? S_INS_WRITE : S_INS_SH_WR;
        end
      end
      // open a slot, one word a cycle from the top down
      S_INS_SH_WR: begin
        k_next = km1;
        if (km1 == pos) begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        n_next = nval;
        if (stat.span_pos && (posp1 < nval_e)) begin
          k_next     = posp1[CW-1:0];
          dst_next   = posp1[CW-1:0];
          state_next = S_PG_CHK;
        end else begin
          state_next = S_INS_FIN;
        end
      end
      // purge: compact the points kept after the new one
      S_PG_CHK: begin
        if (stat.keep) begin
          dst_next = dst + CW'(1);
        end
        if (kp1 < n_e) begin
          k_next = kp1[CW-1:0];
        end else begin
          n_next     = stat.keep ? dst + CW'(1) : dst;
          state_next = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        count_next = n;
        code_next  = repl ? ST_REPLACE : ST_INSERT;
        state_next = S_OUT;
      end
      // range check against first and last point
      S_EV_LO: begin
        if (stat.key_lt) begin
          code_next  = ST_RANGE;
          state_next = S_OUT;
        end else begin
          state_next = S_EV_HI;
        end
      end
      S_EV_HI: begin
        k_next = count - CW'(1);
        if (stat.key_gt) begin
          code_next  = ST_RANGE;
          state_next = S_OUT;
        end else begin
          state_next = S_EV_SCAN;
        end
      end
      S_EV_SCAN: begin
        if ((k != '0) && stat.key_lt) begin
          k_next = km1;
        end else begin
          state_next = S_EV_P2;
        end
      end
      S_EV_P2: state_next = S_EV_P3;
      S_EV_P3: state_next = S_EV_P0;
      S_EV_P0: begin
        div_op_next = DIV_W;
        state_next  = S_EV_DIV;
      end
      S_EV_DIV: state_next = S_EV_DIVW;
      S_EV_DIVW: begin
        if (stat.div_done) begin
          case (div_op)
            DIV_W:   div_op_next = DIV_SA;
            DIV_SA:  div_op_next = DIV_SB;
            DIV_SB:  div_op_next = DIV_SC;
            DIV_SC:  div_op_next = DIV_A1;
            DIV_A1:  div_op_next = DIV_A2;
            default: div_op_next = DIV_W;
          endcase
          if (div_op == DIV_A2) begin
            blend_next = BL_VALUE;
            state_next = S_EV_MLO;
          end else begin
            state_next = S_EV_DIV;
          end
        end
      end
      S_EV_MLO:  state_next = S_EV_MHI;
      S_EV_MHI:  state_next = S_EV_MSUM;
      S_EV_MSUM: state_next = S_EV_MFIN;
      S_EV_MFIN: begin
        case (blend)
          BL_VALUE: begin
            blend_next = BL_SLOPE;
            state_next = S_EV_MLO;
          end
          BL_SLOPE: begin
            blend_next = BL_CURV;
            state_next = S_EV_MLO;
          end
          default: begin
            code_next  = ST_EVAL;
            state_next = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands and RAM addresses
  always_comb begin
    cmd            = '0;
    cmd.pt         = PT_1;
    cmd.div_op     = div_op;
    cmd.mul_step   = MUL_NONE;
    cmd.blend      = blend;
    cmd.out_status = code;
    rd_addr        = '0;
    wr_addr        = '0;
    case (state)
      S_IDLE: cmd.ld_in = in_valid;
      S_START: begin
        if (count != '0) begin
          cmd.rd_en = 1'b1;
          rd_addr   = stat.req_eval ? '0 : km1_of(count);
        end
      end
      S_INS_SCAN: begin
        if (!stat.match && !stat.key_gt && (k != CW'(1))) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km2[AW-1:0];
        end
      end
      S_INS_PLACE: begin
        if ((count != FULL) && (count != pos)) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km1_of(count);
        end
      end
      S_INS_SH_WR: begin
        cmd.wr_en = 1'b1;
        wr_addr   = k[AW-1:0];
        if (km1 != pos) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km2[AW-1:0];
        end
      end
      S_INS_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_new = 1'b1;
        wr_addr    = pos[AW-1:0];
        if (stat.span_pos && (posp1 < nval_e)) begin
          cmd.rd_en = 1'b1;
          rd_addr   = posp1[AW-1:0];
        end
      end
      S_PG_CHK: begin
        if (stat.keep) begin
          cmd.wr_en = 1'b1;
          wr_addr   = dst[AW-1:0];
        end
        if (kp1 < n_e) begin
          cmd.rd_en = 1'b1;
          rd_addr   = kp1[AW-1:0];
        end
      end
      S_EV_LO: begin
        if (!stat.key_lt) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km1_of(count);
        end
      end
      S_EV_SCAN: begin
        if ((k != '0) && stat.key_lt) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km1[AW-1:0];
        end else begin
          cmd.ld_pt = 1'b1;
          cmd.pt    = PT_1;
          if (kp1 < cnt_e) begin
            cmd.rd_en = 1'b1;
            rd_addr   = kp1[AW-1:0];
          end
        end
      end
      S_EV_P2: begin
        cmd.ld_pt  = 1'b1;
        cmd.pt     = PT_2;
        cmd.pt_syn = !(kp1 < cnt_e);
        if (kp2 < cnt_e) begin
          cmd.rd_en = 1'b1;
          rd_addr   = kp2[AW-1:0];
        end
      end
      S_EV_P3: begin
        cmd.ld_pt  = 1'b1;
        cmd.pt     = PT_3;
        cmd.pt_syn = !(kp2 < cnt_e);
        if (k != '0) begin
          cmd.rd_en = 1'b1;
          rd_addr   = km1[AW-1:0];
        end
      end
      S_EV_P0: begin
        cmd.ld_pt  = 1'b1;
        cmd.pt     = PT_0;
        cmd.pt_syn = (k == '0);
      end
      S_EV_DIV:  cmd.div_start = 1'b1;
      S_EV_DIVW: cmd.div_store = stat.div_done;
      S_EV_MLO:  cmd.mul_step  = MUL_LO;
      S_EV_MHI:  cmd.mul_step  = MUL_HI;
      S_EV_MSUM: cmd.mul_step  = MUL_SUM;
      S_EV_MFIN: cmd.mul_step  = MUL_FIN;
      S_OUT: begin
        cmd.out_load = out_free;
        cmd.out_zero = (code != ST_EVAL);
      end
      default: cmd.ld_in = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  // point count never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("point count beyond table depth");

  // a RAM port pair never touches one entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write at the same entry");

  // an accepted word starts a sequence
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_START))
    else $error("accepted word did not start");

  // the count moves only when an insert completes
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != S_INS_FIN) |-> $stable(count))
    else $error("point count changed outside insert completion");

  // a result is never loaded over one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten");
`endif

endmodule

`default_nettype wire

// File: src/sorted_breakpoint_interpolator_core.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_interpolator_core: sorted (x, y) breakpoint table
// Inserts points in x order with replace and purge, and evaluates the
// interpolated value, slope and curvature at a key in Q16.16.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid/in_ready, req_type key_x value_y      | sink
//           | clean_span                                     |
//   out     | out_valid/out_ready, value_out slope_out       | source
//           | curvature_out status point_total               |
//   cfg     | psel penable pwrite paddr pwdata prdata pready | APB slave
//
// One word at a time. Insert scans the table, shifts the points above the
// new one and, with purge, compacts the points after it. Evaluate scans for
// the bracket and runs six divisions on the shared radix-2 divider. Reset is
// synchronous and clears the count and handshake state; the point RAMs are
// not cleared. A waiting result holds the output register; the next word is
// accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_breakpoint_interpolator_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                req_type,
  input  wire logic signed [sbi_pkg::DATA_W-1:0]   key_x,
  input  wire logic signed [sbi_pkg::DATA_W-1:0]   value_y,
  input  wire logic [sbi_pkg::TOL_W-1:0]           clean_span,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [sbi_pkg::DATA_W-1:0]        value_out,
  output logic signed [sbi_pkg::DATA_W-1:0]        slope_out,
  output logic signed [sbi_pkg::DATA_W-1:0]        curvature_out,
  output logic [sbi_pkg::STAT_W-1:0]               status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]         point_total,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import sbi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] total;

  sbi_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .total     (total)
  );

  sbi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .total         (total),
    .req_type      (req_type),
    .key_x         (key_x),
    .value_y       (value_y),
    .clean_span    (clean_span),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .value_out     (value_out),
    .slope_out     (slope_out),
    .curvature_out (curvature_out),
    .status        (status),
    .point_total   (point_total)
  );

endmodule

`default_nettype wire
